[rtl/core/ptb_pkg.sv]
// ----------------------------------------------------------------------------
// ptb_pkg: shared types, constants and helpers for the beat trigger
// Holds field widths, register indexes, result codes and the small
// functions used by the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ptb_pkg;

	// Musical constants.
	localparam int TicksPerQuarter = 96;
	localparam int MaxBarBeats     = 16;

	// Field and datapath widths.
	localparam int LenW   = 5;
	localparam int PatW   = 15;
	localparam int RateW  = 12;
	localparam int TickW  = 32;
	localparam int BeatW  = 4;
	localparam int LevelW = 2;
	localparam int TotW   = 11;                 // up to 16*96 = 1536
	localparam int DvdW   = TickW + 4;          // scaled tick, 36 bits
	localparam int StepW  = 6;                  // up to DvdW iterations
	localparam int PosW   = 15;                 // remainder * bar length
	localparam int ProdW  = TickW + RateW;
	localparam int AddrW  = 5;
	localparam int DataW  = 32;

	// Register indexes on the configuration port.
	localparam logic [2:0] REG_ENABLED    = 3'd0;
	localparam logic [2:0] REG_IS_PRIMARY = 3'd1;
	localparam logic [2:0] REG_BAR_LEN    = 3'd2;
	localparam logic [2:0] REG_PBAR_LEN   = 3'd3;
	localparam logic [2:0] REG_PATTERN    = 3'd4;
	localparam logic [2:0] REG_RATE       = 3'd5;

	// Opcodes of an input request.
	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	// Result levels.
	localparam logic [LevelW-1:0] BEAT_SILENT = 2'd0;
	localparam logic [LevelW-1:0] BEAT_WEAK   = 2'd1;
	localparam logic [LevelW-1:0] BEAT_ACCENT = 2'd2;

	// Division iteration counts.
	localparam logic [StepW-1:0] StepsPrimary = StepW'(TickW);
	localparam logic [StepW-1:0] StepsEff     = StepW'(DvdW);
	localparam logic [StepW-1:0] StepsPos     = StepW'(PosW);

	// Configuration register set.
	typedef struct packed {
		logic              enabled;
		logic              is_primary;
		logic [LenW-1:0]   bar_length;
		logic [LenW-1:0]   primary_bar_length;
		logic [PatW-1:0]   pattern;
		logic [RateW-1:0]  rate_multiplier;
	} cfg_t;

	// Command to the shared divider.
	typedef struct packed {
		logic              start;
		logic [StepW-1:0]  steps;
		logic [DvdW-1:0]   dividend;
		logic [TotW-1:0]   divisor;
	} div_ctrl_t;

	// Status from the shared divider.
	typedef struct packed {
		logic              done;
		logic [BeatW-1:0]  quo;
		logic [TotW-1:0]   rem;
	} div_stat_t;

	// Saturate a bar length to the largest bar.
	function automatic logic [LenW-1:0] clamp_len(input logic [LenW-1:0] v);
		clamp_len = (v > LenW'(MaxBarBeats)) ? LenW'(MaxBarBeats) : v;
	endfunction

	// Ticks in one primary bar.
	function automatic logic [TotW-1:0] total_of(input logic [LenW-1:0] plen);
		total_of = TotW'(plen) * TotW'(TicksPerQuarter);
	endfunction

	// Accent on the downbeat, otherwise weak where the pattern bit is set.
	function automatic logic [LevelW-1:0] level_of(input logic [PatW-1:0] pat,
		input logic [BeatW-1:0] beat);
		logic [BeatW-1:0] idx;
		idx = beat - BeatW'(1);
		if (beat == '0) begin
			level_of = BEAT_ACCENT;
		end else if (idx < BeatW'(PatW) && pat[idx]) begin
			level_of = BEAT_WEAK;
		end else begin
			level_of = BEAT_SILENT;
		end
	endfunction

endpackage

`default_nettype wire

[rtl/core/ptb_cfg.sv]
// ----------------------------------------------------------------------------
// ptb_cfg: configuration registers
// APB-style register file with zero-wait writes and combinational reads.
// ----------------------------------------------------------------------------
`default_nettype none

module ptb_cfg import ptb_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [AddrW-1:0] paddr,
	input  wire logic [DataW-1:0] pwdata,
	output logic      [DataW-1:0] prdata,
	output cfg_t                  cfg
);

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] idx;

	assign idx   = paddr[AddrW-1:2];
	assign wr_en = psel && penable && pwrite;
	assign cfg   = cfg_q;

	// Register writes in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled            <= 1'b1;
			cfg_q.is_primary         <= 1'b1;
			cfg_q.bar_length         <= LenW'(4);
			cfg_q.primary_bar_length <= LenW'(4);
			cfg_q.pattern            <= '0;
			cfg_q.rate_multiplier    <= RateW'(256);
		end else if (wr_en) begin
			unique case (idx)
				REG_ENABLED:    cfg_q.enabled            <= pwdata[0];
				REG_IS_PRIMARY: cfg_q.is_primary         <= pwdata[0];
				REG_BAR_LEN:    cfg_q.bar_length         <= pwdata[LenW-1:0];
				REG_PBAR_LEN:   cfg_q.primary_bar_length <= pwdata[LenW-1:0];
				REG_PATTERN:    cfg_q.pattern            <= pwdata[PatW-1:0];
				REG_RATE:       cfg_q.rate_multiplier    <= pwdata[RateW-1:0];
				default: ;
			endcase
		end
	end

	// Read back.
	always_comb begin
		unique case (idx)
			REG_ENABLED:    prdata = DataW'(cfg_q.enabled);
			REG_IS_PRIMARY: prdata = DataW'(cfg_q.is_primary);
			REG_BAR_LEN:    prdata = DataW'(cfg_q.bar_length);
			REG_PBAR_LEN:   prdata = DataW'(cfg_q.primary_bar_length);
			REG_PATTERN:    prdata = DataW'(cfg_q.pattern);
			REG_RATE:       prdata = DataW'(cfg_q.rate_multiplier);
			default:        prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

[rtl/core/ptb_div.sv]
// ----------------------------------------------------------------------------
// ptb_div: shared radix-2 restoring divider
// Takes a left-aligned dividend and produces one quotient bit per cycle
// for a programmable number of steps; done pulses with the final result.
// ----------------------------------------------------------------------------
`default_nettype none

module ptb_div import ptb_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  div_ctrl_t ctrl,
	output div_stat_t stat
);

	logic [StepW-1:0] cnt_q;
	logic             done_q;
	logic [DvdW-1:0]  dvd_q;
	logic [TotW-1:0]  dsr_q;
	logic [TotW-1:0]  rem_q;
	logic [BeatW-1:0] quo_q;
	logic [TotW:0]    trial;
	logic             ge;

	// One trial subtraction per cycle.
	assign trial = {rem_q, dvd_q[DvdW-1]};
	assign ge    = trial >= {1'b0, dsr_q};

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (ctrl.start) begin
			cnt_q  <= ctrl.steps;
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - StepW'(1);
			done_q <= (cnt_q == StepW'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			dvd_q <= ctrl.dividend;
			dsr_q <= ctrl.divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[DvdW-2:0], 1'b0};
			rem_q <= ge ? TotW'(trial - {1'b0, dsr_q}) : trial[TotW-1:0];
			quo_q <= {quo_q[BeatW-2:0], ge};
		end
	end

	assign stat.done = done_q;
	assign stat.quo  = quo_q;
	assign stat.rem  = rem_q;

endmodule

`default_nettype wire

[rtl/core/polyrhythm_beat_trigger_unit.sv]
// ----------------------------------------------------------------------------
// polyrhythm_beat_trigger_unit: per-tick beat level decision
// Sequencer around one shared divider that finds the beat of each tick
// in plain modulo mode or scaled polyrhythm mode, with trigger dedupe.
//
//   Channel   Direction  Payload
//   s_*       in         tuser: opcode; tdata: tick[31:0]
//   m_*       out        tdata: beat_state[1:0], beat_position[5:2]
//   APB       in/out     six registers at byte addresses 0x00..0x14
//
// A restart or a disabled channel goes straight from the decision to the
// final state. The radix-2 divider runs 32 steps in plain mode, or 36 plus
// 15 steps in polyrhythm mode. The block takes a new request while its last
// result still waits on m_tready. Reset clears the trigger memory and loads
// the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module polyrhythm_beat_trigger_unit import ptb_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// Input stream.
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [TickW-1:0] s_tdata,   // tick[31:0]
	input  wire logic             s_tuser,   // opcode
	// Output stream.
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic      [7:0]       m_tdata,   // beat_state[1:0], beat_position[5:2], zero
	// Configuration port.
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [AddrW-1:0] paddr,
	input  wire logic [DataW-1:0] pwdata,
	output logic      [DataW-1:0] prdata,
	output logic                  pready
);

	typedef enum logic [10:0] {
		ST_IDLE   = 11'b000_0000_0001,
		ST_DECIDE = 11'b000_0000_0010,
		ST_MUL    = 11'b000_0000_0100,
		ST_DIVP   = 11'b000_0000_1000,
		ST_WAITP  = 11'b000_0001_0000,
		ST_DIVA   = 11'b000_0010_0000,
		ST_WAITA  = 11'b000_0100_0000,
		ST_DIVB   = 11'b000_1000_0000,
		ST_WAITB  = 11'b001_0000_0000,
		ST_EVAL   = 11'b010_0000_0000,
		ST_FIN    = 11'b100_0000_0000
	} state_t;

	state_t            state_q;
	cfg_t              cfg;
	div_ctrl_t         div_ctrl;
	div_stat_t         div_stat;

	logic              op_q;
	logic [TickW-1:0]  tick_q;
	logic [LenW-1:0]   len_q;
	logic [TotW-1:0]   total_q;
	logic [ProdW-1:0]  prod_q;
	logic [PosW-1:0]   pos_q;
	logic [BeatW-1:0]  beat_q;
	logic [TotW-1:0]   rem_q;
	logic [LevelW-1:0] level_q;

	logic [BeatW-1:0]  last_beat_q;
	logic              last_valid_q;
	logic [TickW-1:0]  last_tick_q;

	logic              m_tvalid_q;
	logic [7:0]        m_tdata_q;

	logic [LenW-1:0]   len_c;
	logic [LenW-1:0]   plen_c;
	logic [PosW-1:0]   rem20;
	logic [PosW-1:0]   total19;
	logic [TickW-1:0]  tick_gap;
	logic              in_window;
	logic              fire;
	logic              out_free;

	ptb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	ptb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (div_ctrl),
		.stat   (div_stat)
	);

	assign pready   = 1'b1;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign out_free = !m_tvalid_q || m_tready;

	assign len_c  = clamp_len(cfg.bar_length);
	assign plen_c = clamp_len(cfg.primary_bar_length);

	// Divider commands are issued for one cycle from the start states.
	always_comb begin
		div_ctrl.start    = 1'b0;
		div_ctrl.steps    = StepsPrimary;
		div_ctrl.dividend = {tick_q, 4'b0000};
		div_ctrl.divisor  = TotW'(len_q);
		unique case (state_q)
			ST_DIVP: begin
				div_ctrl.start = 1'b1;
			end
			ST_DIVA: begin
				div_ctrl.start    = 1'b1;
				div_ctrl.steps    = StepsEff;
				div_ctrl.dividend = prod_q[ProdW-1:8];
				div_ctrl.divisor  = total_q;
			end
			ST_DIVB: begin
				div_ctrl.start    = 1'b1;
				div_ctrl.steps    = StepsPos;
				div_ctrl.dividend = {pos_q, (DvdW-PosW)'(0)};
				div_ctrl.divisor  = total_q;
			end
			default: ;
		endcase
	end

	// Edge window and dedupe test on the registered beat and remainder.
	assign rem20     = PosW'(rem_q) * PosW'(20);
	assign total19   = PosW'(total_q) * PosW'(19);
	assign tick_gap  = tick_q - last_tick_q;
	assign in_window = (rem20 < PosW'(total_q)) || (rem20 > total19);
	assign fire      = in_window && (!last_valid_q || beat_q != last_beat_q ||
		tick_gap > TickW'(total_q[TotW-1:1]));

	// Sequencer and trigger memory.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			last_beat_q  <= '0;
			last_valid_q <= 1'b0;
			last_tick_q  <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			// A taken result drops here unless the final state reloads it.
			if (m_tvalid_q && m_tready && state_q != ST_FIN) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (op_q == OP_RESTART) begin
						last_beat_q  <= '0;
						last_valid_q <= 1'b0;
						last_tick_q  <= '0;
						state_q      <= ST_FIN;
					end else if (!cfg.enabled || len_q == '0) begin
						state_q <= ST_FIN;
					end else if (cfg.is_primary) begin
						state_q <= ST_DIVP;
					end else if (plen_c == '0) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL:   state_q <= ST_DIVA;
				ST_DIVP:  state_q <= ST_WAITP;
				ST_WAITP: begin
					if (div_stat.done) begin
						state_q <= ST_FIN;
					end
				end
				ST_DIVA:  state_q <= ST_WAITA;
				ST_WAITA: begin
					if (div_stat.done) begin
						state_q <= ST_DIVB;
					end
				end
				ST_DIVB:  state_q <= ST_WAITB;
				ST_WAITB: begin
					if (div_stat.done) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (fire) begin
						last_beat_q  <= beat_q;
						last_valid_q <= 1'b1;
						last_tick_q  <= tick_q;
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				op_q    <= s_tuser;
				tick_q  <= s_tdata;
				len_q   <= len_c;
				total_q <= total_of(plen_c);
			end
			ST_DECIDE: begin
				beat_q  <= '0;
				level_q <= BEAT_SILENT;
			end
			ST_MUL: begin
				prod_q <= ProdW'(tick_q) * ProdW'(cfg.rate_multiplier);
			end
			ST_WAITP: begin
				if (div_stat.done) begin
					beat_q  <= div_stat.rem[BeatW-1:0];
					level_q <= level_of(cfg.pattern, div_stat.rem[BeatW-1:0]);
				end
			end
			ST_WAITA: begin
				if (div_stat.done) begin
					pos_q <= PosW'(div_stat.rem) * PosW'(len_q);
				end
			end
			ST_WAITB: begin
				if (div_stat.done) begin
					beat_q <= div_stat.quo;
					rem_q  <= div_stat.rem;
				end
			end
			ST_EVAL: begin
				level_q <= fire ? level_of(cfg.pattern, beat_q) : BEAT_SILENT;
			end
			ST_FIN: begin
				if (out_free) begin
					m_tdata_q <= {2'b00, beat_q, level_q};
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire
